// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros used by the checker.
// Each macro places one labelled concurrent assertion, sampled on the rising
// clock edge and switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// ----- src/mcra_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcra_pkg
// Types and constants shared by the mean and RMS accumulator controller,
// datapath, top level and checker.
// ----------------------------------------------------------------------------
package mcra_pkg;

   // Fixed field widths of the transaction formats.
   localparam int ACTION_W = 2;
   localparam int CHAN_W   = 2;
   localparam int RES_W    = 24;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [RES_W-1:0]  result_type;

   // Largest value a result field can carry; larger quotients saturate here.
   localparam result_type RES_MAX = '1;

   // Action codes carried on the request side.
   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR = 2'd0,
      ACT_ACCUM = 2'd1,
      ACT_END   = 2'd2
   } action_type;

   // Operations the controller asks of the datapath, one per cycle.
   typedef enum logic [3:0] {
      DP_NOP       = 4'd0,
      DP_CLEAR     = 4'd1,
      DP_DROP      = 4'd2,
      DP_CAPTURE   = 4'd3,
      DP_ACC       = 4'd4,
      DP_MUL_INIT  = 4'd5,
      DP_MUL_STEP  = 4'd6,
      DP_SUB       = 4'd7,
      DP_SQRT_STEP = 4'd8,
      DP_DIVR_INIT = 4'd9,
      DP_DIVM_INIT = 4'd10,
      DP_DIV_STEP  = 4'd11
   } dp_op_type;

   // Command from controller to datapath.
   typedef struct packed {
      dp_op_type op;
      logic      out_load;
      logic      out_last;
   } dp_cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic count_zero;
      logic count_full;
      logic step_last;
   } dp_status_type;

endpackage

// ----- src/multi_channel_mean_rms_accumulator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_mean_rms_accumulator_core
// Accumulate transactions run all channel lanes in parallel. An end
// transaction with a nonzero event count yields one result per channel,
// each computed by the bit-serial multiply, square root and two divides.
// Reset zeroes the sums, count and overflow flag.
// ----------------------------------------------------------------------------
module multi_channel_mean_rms_accumulator_core #(
   parameter int CHANNELS    = 4,
   parameter int SAMPLE_BITS = 20,
   parameter int COUNT_BITS  = 16
) (
   input  logic clock,
   input  logic reset,
   // Request channel.
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // energy_ch0 .. energy_chN, SAMPLE_BITS each, channel 0 lowest
   input  logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   // action
   input  logic [mcra_pkg::ACTION_W-1:0]             req_tuser,
   // Response channel.
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // mean_q4 [23:0], rms_q4 [47:24]
   output logic [2*mcra_pkg::RES_W-1:0]              rsp_tdata,
   // channel [1:0], overflow [2]
   output logic [mcra_pkg::CHAN_W:0]                 rsp_tuser,
   output logic                                      rsp_tlast
);

   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   mcra_pkg::dp_cmd_type    cmd;
   mcra_pkg::dp_status_type status;
   logic [CH_IDX_W-1:0]     ch_idx;
   mcra_pkg::chan_type      out_chan;
   mcra_pkg::result_type    out_mean;
   mcra_pkg::result_type    out_rms;
   logic                    out_ovf;

   // Sequencer.
   mcra_ctrl #(
      .CHANNELS(CHANNELS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd),
      .ch_idx     (ch_idx)
   );

   // Accumulators and arithmetic units.
   mcra_dpath #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_tdata),
      .cmd      (cmd),
      .ch_idx   (ch_idx),
      .status   (status),
      .out_chan (out_chan),
      .out_mean (out_mean),
      .out_rms  (out_rms),
      .out_last (rsp_tlast),
      .out_ovf  (out_ovf)
   );

   // Response packing.
   assign rsp_tdata = {out_rms, out_mean};
   assign rsp_tuser = {out_ovf, out_chan};

endmodule

// ----- src/mcra_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcra_ctrl
// Sequencer for the accumulator: takes request transactions, steps the
// datapath through multiply, square root and divide per channel, and owns
// the valid flag of the response register.
// ----------------------------------------------------------------------------
module mcra_ctrl #(
   parameter int CHANNELS = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [mcra_pkg::ACTION_W-1:0] req_action,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  mcra_pkg::dp_status_type      status,
   output mcra_pkg::dp_cmd_type         cmd,
   output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] ch_idx
);

   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(CHANNELS - 1);

   typedef enum logic [10:0] {
      ST_IDLE      = 11'b000_0000_0001,
      ST_ACC       = 11'b000_0000_0010,
      ST_LOAD      = 11'b000_0000_0100,
      ST_MUL       = 11'b000_0000_1000,
      ST_SUB       = 11'b000_0001_0000,
      ST_SQRT      = 11'b000_0010_0000,
      ST_DIVR_INIT = 11'b000_0100_0000,
      ST_DIVR      = 11'b000_1000_0000,
      ST_DIVM_INIT = 11'b001_0000_0000,
      ST_DIVM      = 11'b010_0000_0000,
      ST_PUSH      = 11'b100_0000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [CH_IDX_W-1:0]  ch_ff, ch_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   mcra_pkg::action_type action;

   assign action     = mcra_pkg::action_type'(req_action);
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign ch_idx     = ch_ff;

   // Next state, channel index, response valid and datapath command.
   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd.op       = mcra_pkg::DP_NOP;
      cmd.out_load = 1'b0;
      cmd.out_last = (ch_ff == LAST_CH);

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (action)
                  mcra_pkg::ACT_CLEAR: begin
                     cmd.op = mcra_pkg::DP_CLEAR;
                  end
                  mcra_pkg::ACT_ACCUM: begin
                     if (status.count_full) begin
                        cmd.op = mcra_pkg::DP_DROP;
                     end else begin
                        cmd.op   = mcra_pkg::DP_CAPTURE;
                        state_in = ST_ACC;
                     end
                  end
                  mcra_pkg::ACT_END: begin
                     if (!status.count_zero) begin
                        ch_in    = '0;
                        state_in = ST_LOAD;
                     end
                  end
                  default: begin
                     // Unused action code: no effect.
                  end
               endcase
            end
         end
         ST_ACC: begin
            cmd.op   = mcra_pkg::DP_ACC;
            state_in = ST_IDLE;
         end
         ST_LOAD: begin
            cmd.op   = mcra_pkg::DP_MUL_INIT;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.op = mcra_pkg::DP_MUL_STEP;
            if (status.step_last) begin
               state_in = ST_SUB;
            end
         end
         ST_SUB: begin
            cmd.op   = mcra_pkg::DP_SUB;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.op = mcra_pkg::DP_SQRT_STEP;
            if (status.step_last) begin
               state_in = ST_DIVR_INIT;
            end
         end
         ST_DIVR_INIT: begin
            cmd.op   = mcra_pkg::DP_DIVR_INIT;
            state_in = ST_DIVR;
         end
         ST_DIVR: begin
            cmd.op = mcra_pkg::DP_DIV_STEP;
            if (status.step_last) begin
               state_in = ST_DIVM_INIT;
            end
         end
         ST_DIVM_INIT: begin
            cmd.op   = mcra_pkg::DP_DIVM_INIT;
            state_in = ST_DIVM;
         end
         ST_DIVM: begin
            cmd.op = mcra_pkg::DP_DIV_STEP;
            if (status.step_last) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            // Load the response register once it is empty or being drained.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               if (ch_ff == LAST_CH) begin
                  state_in = ST_IDLE;
               end else begin
                  ch_in    = ch_ff + CH_IDX_W'(1);
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- src/mcra_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcra_dpath
// Per-channel sums and sums of squares, event count and drop flag, plus the
// shared shift-add multiplier, digit-by-digit square root and restoring
// divider that turn the sums into mean and RMS, and the response register.
// ----------------------------------------------------------------------------
module mcra_dpath #(
   parameter int CHANNELS    = 4,
   parameter int SAMPLE_BITS = 20,
   parameter int COUNT_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] req_data,
   input  mcra_pkg::dp_cmd_type                 cmd,
   input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] ch_idx,
   output mcra_pkg::dp_status_type              status,
   output mcra_pkg::chan_type                   out_chan,
   output mcra_pkg::result_type                 out_mean,
   output mcra_pkg::result_type                 out_rms,
   output logic                                 out_last,
   output logic                                 out_ovf
);

   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SQR_W    = 2 * SAMPLE_BITS;
   localparam int SUM_W    = SAMPLE_BITS + COUNT_BITS;
   localparam int SQ_W     = 2 * SAMPLE_BITS + COUNT_BITS;
   localparam int PROD_W   = 2 * SUM_W;
   localparam int ROOT_W   = SUM_W + 4;
   localparam int X_W      = 2 * ROOT_W;
   localparam int DIV_W    = SUM_W + 4;
   localparam int RES_W    = mcra_pkg::RES_W;
   localparam int EXT_W    = (DIV_W > RES_W) ? DIV_W : RES_W;
   localparam int STEP_W   = $clog2(DIV_W + 1);

   // Sample lanes and their squares, one multiplier per lane.
   logic [SAMPLE_BITS-1:0] lane_smp [CHANNELS];
   logic [SQR_W-1:0]       lane_sqr [CHANNELS];

   for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
      assign lane_smp[g] = req_data[g*SAMPLE_BITS +: SAMPLE_BITS];
      assign lane_sqr[g] = SQR_W'(lane_smp[g]) * SQR_W'(lane_smp[g]);
   end

   // Accumulation state.
   logic [SAMPLE_BITS-1:0] smp_ff [CHANNELS];
   logic [SAMPLE_BITS-1:0] smp_in [CHANNELS];
   logic [SQR_W-1:0]       sqr_ff [CHANNELS];
   logic [SQR_W-1:0]       sqr_in [CHANNELS];
   logic [SUM_W-1:0]       sum_ff [CHANNELS];
   logic [SUM_W-1:0]       sum_in [CHANNELS];
   logic [SQ_W-1:0]        sq_ff  [CHANNELS];
   logic [SQ_W-1:0]        sq_in  [CHANNELS];
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   drop_ff, drop_in;

   // Arithmetic unit state.
   logic [SQ_W-1:0]        mc_sq_ff, mc_sq_in;
   logic [SUM_W-1:0]       mc_s_ff, mc_s_in;
   logic [SUM_W-1:0]       mp_n_ff, mp_n_in;
   logic [SUM_W-1:0]       mp_s_ff, mp_s_in;
   logic [PROD_W-1:0]      acc_a_ff, acc_a_in;
   logic [PROD_W-1:0]      acc_b_ff, acc_b_in;
   logic [X_W-1:0]         x_ff, x_in;
   logic [ROOT_W+1:0]      rem_ff, rem_in;
   logic [ROOT_W-1:0]      root_ff, root_in;
   logic [DIV_W-1:0]       dvd_ff, dvd_in;
   logic [COUNT_BITS-1:0]  drem_ff, drem_in;
   mcra_pkg::result_type   rms_res_ff, rms_res_in;
   logic [STEP_W-1:0]      step_ff, step_in;

   // Response register.
   mcra_pkg::chan_type     out_chan_ff, out_chan_in;
   mcra_pkg::result_type   out_mean_ff, out_mean_in;
   mcra_pkg::result_type   out_rms_ff, out_rms_in;
   logic                   out_last_ff, out_last_in;
   logic                   out_ovf_ff, out_ovf_in;

   // Variance difference with borrow.
   logic [PROD_W:0]        diff_full;
   assign diff_full = {1'b0, acc_a_ff} - {1'b0, acc_b_ff};

   // Square root trial.
   logic [ROOT_W+1:0]      rem_shift;
   logic [ROOT_W+1:0]      root_trial;
   logic                   root_fits;
   assign rem_shift  = {rem_ff[ROOT_W-1:0], x_ff[X_W-1 -: 2]};
   assign root_trial = {root_ff, 2'b01};
   assign root_fits  = (rem_shift >= root_trial);

   // Divider trial.
   logic [COUNT_BITS:0]    div_trial;
   logic [COUNT_BITS:0]    div_sub;
   logic                   div_fits;
   assign div_trial = {drem_ff, dvd_ff[DIV_W-1]};
   assign div_sub   = div_trial - {1'b0, count_ff};
   assign div_fits  = (div_trial >= {1'b0, count_ff});

   // Quotient saturated to the result width.
   logic [EXT_W-1:0]       quot_ext;
   mcra_pkg::result_type   quot_sat;
   assign quot_ext = EXT_W'(dvd_ff);
   assign quot_sat = (quot_ext > EXT_W'(mcra_pkg::RES_MAX)) ? mcra_pkg::RES_MAX
                                                            : quot_ext[RES_W-1:0];

   assign status.count_zero = (count_ff == '0);
   assign status.count_full = &count_ff;
   assign status.step_last  = (step_ff == STEP_W'(1));

   assign out_chan = out_chan_ff;
   assign out_mean = out_mean_ff;
   assign out_rms  = out_rms_ff;
   assign out_last = out_last_ff;
   assign out_ovf  = out_ovf_ff;

   // Next values for the datapath registers under the current operation.
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         smp_in[c] = smp_ff[c];
         sqr_in[c] = sqr_ff[c];
         sum_in[c] = sum_ff[c];
         sq_in[c]  = sq_ff[c];
      end
      count_in   = count_ff;
      drop_in    = drop_ff;
      mc_sq_in   = mc_sq_ff;
      mc_s_in    = mc_s_ff;
      mp_n_in    = mp_n_ff;
      mp_s_in    = mp_s_ff;
      acc_a_in   = acc_a_ff;
      acc_b_in   = acc_b_ff;
      x_in       = x_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      dvd_in     = dvd_ff;
      drem_in    = drem_ff;
      rms_res_in = rms_res_ff;
      step_in    = step_ff;

      unique case (cmd.op)
         mcra_pkg::DP_NOP: begin
         end
         mcra_pkg::DP_CLEAR: begin
            for (int c = 0; c < CHANNELS; c++) begin
               sum_in[c] = '0;
               sq_in[c]  = '0;
            end
            count_in = '0;
            drop_in  = 1'b0;
         end
         mcra_pkg::DP_DROP: begin
            drop_in = 1'b1;
         end
         mcra_pkg::DP_CAPTURE: begin
            for (int c = 0; c < CHANNELS; c++) begin
               smp_in[c] = lane_smp[c];
               sqr_in[c] = lane_sqr[c];
            end
         end
         mcra_pkg::DP_ACC: begin
            for (int c = 0; c < CHANNELS; c++) begin
               sum_in[c] = sum_ff[c] + SUM_W'(smp_ff[c]);
               sq_in[c]  = sq_ff[c] + SQ_W'(sqr_ff[c]);
            end
            count_in = count_ff + COUNT_BITS'(1);
         end
         mcra_pkg::DP_MUL_INIT: begin
            mc_sq_in = sq_ff[ch_idx];
            mc_s_in  = sum_ff[ch_idx];
            mp_n_in  = SUM_W'(count_ff);
            mp_s_in  = sum_ff[ch_idx];
            acc_a_in = '0;
            acc_b_in = '0;
            step_in  = STEP_W'(SUM_W);
         end
         mcra_pkg::DP_MUL_STEP: begin
            // N * sumsq and sum * sum, one multiplier bit per cycle, MSB first.
            acc_a_in = {acc_a_ff[PROD_W-2:0], 1'b0}
                     + (mp_n_ff[SUM_W-1] ? PROD_W'(mc_sq_ff) : '0);
            acc_b_in = {acc_b_ff[PROD_W-2:0], 1'b0}
                     + (mp_s_ff[SUM_W-1] ? PROD_W'(mc_s_ff) : '0);
            mp_n_in  = {mp_n_ff[SUM_W-2:0], 1'b0};
            mp_s_in  = {mp_s_ff[SUM_W-2:0], 1'b0};
            step_in  = step_ff - STEP_W'(1);
         end
         mcra_pkg::DP_SUB: begin
            // A negative variance gives a zero radicand.
            x_in    = diff_full[PROD_W] ? '0 : {diff_full[PROD_W-1:0], 8'd0};
            rem_in  = '0;
            root_in = '0;
            step_in = STEP_W'(ROOT_W);
         end
         mcra_pkg::DP_SQRT_STEP: begin
            x_in = {x_ff[X_W-3:0], 2'b00};
            if (root_fits) begin
               rem_in  = rem_shift - root_trial;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            step_in = step_ff - STEP_W'(1);
         end
         mcra_pkg::DP_DIVR_INIT: begin
            dvd_in  = DIV_W'(root_ff);
            drem_in = '0;
            step_in = STEP_W'(DIV_W);
         end
         mcra_pkg::DP_DIVM_INIT: begin
            rms_res_in = quot_sat;
            dvd_in     = {mc_s_ff, 4'd0};
            drem_in    = '0;
            step_in    = STEP_W'(DIV_W);
         end
         mcra_pkg::DP_DIV_STEP: begin
            // Restoring division by the event count, one quotient bit a cycle.
            drem_in = div_fits ? div_sub[COUNT_BITS-1:0] : div_trial[COUNT_BITS-1:0];
            dvd_in  = {dvd_ff[DIV_W-2:0], div_fits};
            step_in = step_ff - STEP_W'(1);
         end
         default: begin
         end
      endcase
   end

   // Response register load.
   always_comb begin
      out_chan_in = out_chan_ff;
      out_mean_in = out_mean_ff;
      out_rms_in  = out_rms_ff;
      out_last_in = out_last_ff;
      out_ovf_in  = out_ovf_ff;
      if (cmd.out_load) begin
         out_chan_in = mcra_pkg::chan_type'(ch_idx);
         out_mean_in = quot_sat;
         out_rms_in  = rms_res_ff;
         out_last_in = cmd.out_last;
         out_ovf_in  = drop_ff;
      end
   end

   // Sums, count and flag, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            sum_ff[c] <= '0;
            sq_ff[c]  <= '0;
         end
         count_ff <= '0;
         drop_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         for (int c = 0; c < CHANNELS; c++) begin
            sum_ff[c] <= sum_in[c];
            sq_ff[c]  <= sq_in[c];
         end
         count_ff <= count_in;
         drop_ff  <= drop_in;
         step_ff  <= step_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      for (int c = 0; c < CHANNELS; c++) begin
         smp_ff[c] <= smp_in[c];
         sqr_ff[c] <= sqr_in[c];
      end
      mc_sq_ff    <= mc_sq_in;
      mc_s_ff     <= mc_s_in;
      mp_n_ff     <= mp_n_in;
      mp_s_ff     <= mp_s_in;
      acc_a_ff    <= acc_a_in;
      acc_b_ff    <= acc_b_in;
      x_ff        <= x_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      dvd_ff      <= dvd_in;
      drem_ff     <= drem_in;
      rms_res_ff  <= rms_res_in;
      out_chan_ff <= out_chan_in;
      out_mean_ff <= out_mean_in;
      out_rms_ff  <= out_rms_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

endmodule

// ----- src/mcra_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcra_chk
// Port-level checks on the accumulator core, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcra_chk #(
   parameter int CHANNELS = 4
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [2*mcra_pkg::RES_W-1:0]     rsp_tdata,
   input logic [mcra_pkg::CHAN_W:0]        rsp_tuser,
   input logic                             rsp_tlast
);

   localparam mcra_pkg::chan_type LAST_CHAN = mcra_pkg::chan_type'(CHANNELS - 1);

   // Views of the response port used by the checks below.
   logic [2*mcra_pkg::RES_W+mcra_pkg::CHAN_W+1:0] rsp_word;
   mcra_pkg::chan_type                            rsp_chan;
   logic                                          rsp_stall;
   logic                                          rsp_take_mid;

   assign rsp_word     = {rsp_tlast, rsp_tuser, rsp_tdata};
   assign rsp_chan     = rsp_tuser[mcra_pkg::CHAN_W-1:0];
   assign rsp_stall    = rsp_tvalid && !rsp_tready;
   assign rsp_take_mid = rsp_tvalid && rsp_tready && !rsp_tlast;

   // A stalled response keeps its contents.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))

   // The final result of a run belongs to the highest channel.
   `ASSERT_IMPL(a_last_chan, clock, reset, rsp_tvalid && rsp_tlast, rsp_chan == LAST_CHAN)

   // While a run is still emitting, no new request is taken.
   `ASSERT_IMPL(a_busy_in_run, clock, reset, rsp_tvalid && !rsp_tlast, !req_tready)

   // Once a result that is not the last is taken, the register either empties
   // or moves straight on to the next channel.
   `ASSERT_NEXT(a_run_gap, clock, reset, rsp_take_mid, !rsp_tvalid || $changed(rsp_chan))

endmodule

bind multi_channel_mean_rms_accumulator_core mcra_chk #(
   .CHANNELS(CHANNELS)
) u_mcra_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
